// ----- design/bpas_pkg.sv -----
// Shared types and constants of the banked port access scheduler.
`default_nettype none
package bpas_pkg;

    localparam int CYC_W = 48;
    localparam int OFS_W = 25;
    localparam int DIV_N = 25;
    localparam int DSR_W = 7;
    localparam logic [24:0] MAX_CAP = 25'd16777216;

    // Result error codes.
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_OVF   = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] CFG_CAPACITY = 3'd0;
    localparam logic [2:0] CFG_WIDTH    = 3'd1;
    localparam logic [2:0] CFG_LATENCY  = 3'd2;
    localparam logic [2:0] CFG_DMA_BEAT = 3'd3;
    localparam logic [2:0] CFG_DMA_SET  = 3'd4;

    typedef struct packed {
        logic              cmd;
        logic [CYC_W-1:0]  arrival_cycle;
        logic [OFS_W-1:0]  byte_offset;
        logic [OFS_W-1:0]  byte_length;
        logic              is_write;
    } req_t;

    typedef struct packed {
        logic [CYC_W-1:0]  start_cycle;
        logic [CYC_W-1:0]  completion_cycle;
        logic [CYC_W-1:0]  service_cycles;
        logic [CYC_W-1:0]  queue_cycles;
        logic [OFS_W-1:0]  conflict_count;
        logic [1:0]        error_code;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIV_A,
        ST_BEAT,
        ST_FIN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       div_a_go;
        logic       beat_init;
        logic       beat_step;
        logic       emit;
        logic [1:0] err;
    } ctl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic range_err;
        logic first_ovf;
        logic beat_ovf;
        logic last_beat;
    } ctl_sts_t;

endpackage
`default_nettype wire

// ----- design/bpas_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle, with the quotient kept mod BANKS.
`default_nettype none
module bpas_div
    import bpas_pkg::*;
#(
    parameter int BANKS = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             go,
    input  wire logic [DIV_N-1:0] dividend,
    input  wire logic [DSR_W-1:0] divisor,
    output logic [DSR_W-1:0]      remainder,
    output logic [((BANKS > 1) ? $clog2(BANKS) : 1)-1:0] qmod,
    output logic                  done
);

    localparam int MW = (BANKS > 1) ? $clog2(BANKS) : 1;

    logic [DSR_W-1:0] rem_reg, rem_next;
    logic [DIV_N-1:0] quo_reg, quo_next;
    logic [MW-1:0]    qm_reg, qm_next;
    logic [DSR_W-1:0] dsr_reg;
    logic [4:0]       cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DSR_W:0]   trial;
    logic             ge;
    logic [MW:0]      qm_dbl;

    // One restoring step on the partial remainder; the new quotient bit
    // also shifts into a running residue mod BANKS.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_N-1]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? DSR_W'(trial - {1'b0, dsr_reg}) : trial[DSR_W-1:0];
        quo_next = {quo_reg[DIV_N-2:0], ge};
        qm_dbl   = {qm_reg, ge};
        qm_next  = (qm_dbl >= (MW+1)'(BANKS)) ? MW'(qm_dbl - (MW+1)'(BANKS))
                                               : qm_dbl[MW-1:0];
    end

    // Control of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(DIV_N - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Operand registers.
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
            qm_reg  <= '0;
        end
        else if (run_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            qm_reg  <= qm_next;
        end
    end

    assign remainder = rem_reg;
    assign qmod      = qm_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

// ----- design/bpas_ctrl.sv -----
// Controller state machine that sequences one request through the datapath.
`default_nettype none
module bpas_ctrl
    import bpas_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ctl_sts_t sts,
    output ctl_cmd_t      cmd,
    output logic          busy
);

    state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err    = ERR_OK;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.range_err)
                begin
                    cmd.emit   = 1'b1;
                    cmd.err    = ERR_RANGE;
                    state_next = ST_IDLE;
                end
                else if (sts.first_ovf)
                begin
                    cmd.emit   = 1'b1;
                    cmd.err    = ERR_OVF;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cmd.div_a_go = 1'b1;
                    state_next   = ST_DIV_A;
                end
            end
            ST_DIV_A:
            begin
                if (sts.div_done)
                begin
                    cmd.beat_init = 1'b1;
                    state_next    = ST_BEAT;
                end
            end
            ST_BEAT:
            begin
                cmd.beat_step = 1'b1;
                if (sts.beat_ovf)
                begin
                    cmd.emit   = 1'b1;
                    cmd.err    = ERR_OVF;
                    state_next = ST_IDLE;
                end
                else if (sts.last_beat)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.emit   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule
`default_nettype wire

// ----- design/bpas_dp.sv -----
// Datapath: configuration, port bookings, bank stepping and result register.
`default_nettype none
module bpas_dp
    import bpas_pkg::*;
#(
    parameter int BANKS       = 8,
    parameter int READ_PORTS  = 2,
    parameter int WRITE_PORTS = 1
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire req_t       req,
    input  wire ctl_cmd_t   cmd,
    output ctl_sts_t        sts,
    input  wire logic       cfg_wen,
    input  wire logic [2:0] cfg_index,
    input  wire logic [24:0] cfg_data,
    output rsp_t            rsp,
    output logic            done
);

    localparam int NR  = BANKS * READ_PORTS;
    localparam int NW  = BANKS * WRITE_PORTS;
    localparam int BW  = (BANKS > 1) ? $clog2(BANKS) : 1;
    localparam int RIW = (NR > 1) ? $clog2(NR) : 1;
    localparam int WIW = (NW > 1) ? $clog2(NW) : 1;
    localparam int RPW = (READ_PORTS > 1) ? $clog2(READ_PORTS) : 1;
    localparam int WPW = (WRITE_PORTS > 1) ? $clog2(WRITE_PORTS) : 1;

    // Configuration registers.
    logic [24:0] cap_reg;
    logic [6:0]  width_reg;
    logic [7:0]  lat_reg;
    logic [10:0] dbeat_reg;
    logic [15:0] dset_reg;

    // Port bookings: committed copy and working copy of the request.
    logic [CYC_W-1:0] rd_free_reg [NR];
    logic [CYC_W-1:0] wr_free_reg [NW];
    logic [CYC_W-1:0] rd_work_reg [NR];
    logic [CYC_W-1:0] wr_work_reg [NW];
    logic [CYC_W-1:0] eng_reg;

    // Request and progress registers.
    req_t             req_reg;
    logic [DSR_W-1:0] br_reg, r_reg;
    logic [BW-1:0]    bank_reg, bqm_reg;
    logic [CYC_W-1:0] issue_reg, comp_reg;
    logic [OFS_W-1:0] conf_reg;
    logic [OFS_W:0]   proc_reg;
    rsp_t             rsp_reg;
    logic             done_reg;

    // Effective configuration values.
    logic [24:0]      cap_eff;
    logic [6:0]       stripe;
    logic [7:0]       lat;
    logic [10:0]      beat;
    logic [15:0]      setup;
    logic [CYC_W-1:0] start_c;
    logic [CYC_W:0]   first_c;

    // Divider connections.
    logic             d_go;
    logic [DIV_N-1:0] d0_dvd, d1_dvd;
    logic [DSR_W-1:0] dsr, d0_r, d1_r;
    logic [BW-1:0]    d0_m, d1_m;
    logic             d0_done, d1_done;

    // Beat scheduling signals.
    logic [CYC_W-1:0] rbest_v, wbest_v, pv, sel;
    logic [RPW-1:0]   rbest_i;
    logic [WPW-1:0]   wbest_i;
    logic [RIW-1:0]   ridx;
    logic [WIW-1:0]   widx;
    logic [CYC_W:0]   sel_lat;
    logic [DSR_W:0]   r_sum;
    logic [DSR_W-1:0] r_new;
    logic             carry;
    logic [BW+1:0]    b_sum;
    logic [BW-1:0]    bank_new;
    logic [OFS_W+1:0] proc_sum;

    always_comb
    begin
        cap_eff = (cap_reg > MAX_CAP) ? MAX_CAP : cap_reg;
        stripe  = (width_reg == 7'd0) ? 7'd1 : ((width_reg > 7'd64) ? 7'd64 : width_reg);
        lat     = (lat_reg == 8'd0) ? 8'd1 : lat_reg;
        if (req_reg.cmd)
        begin
            beat  = (dbeat_reg == 11'd0) ? 11'd1
                  : ((dbeat_reg > 11'd1024) ? 11'd1024 : dbeat_reg);
            setup = dset_reg;
        end
        else
        begin
            beat  = 11'(stripe);
            setup = 16'd0;
        end
    end

    // Service start and first beat cycle.
    always_comb
    begin
        start_c = (req_reg.cmd && (eng_reg > req_reg.arrival_cycle))
                ? eng_reg : req_reg.arrival_cycle;
        first_c = {1'b0, start_c} + (CYC_W+1)'(setup);
    end

    // Dividers: offset and beat by the stripe; each keeps its quotient mod BANKS.
    assign d_go   = cmd.div_a_go;
    assign d0_dvd = req_reg.byte_offset;
    assign d1_dvd = DIV_N'(beat);
    assign dsr    = stripe;

    bpas_div #(
        .BANKS (BANKS)
    ) u_div0 (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (d_go),
        .dividend  (d0_dvd),
        .divisor   (dsr),
        .remainder (d0_r),
        .qmod      (d0_m),
        .done      (d0_done)
    );

    bpas_div #(
        .BANKS (BANKS)
    ) u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (d_go),
        .dividend  (d1_dvd),
        .divisor   (dsr),
        .remainder (d1_r),
        .qmod      (d1_m),
        .done      (d1_done)
    );

    // Earliest-free port of the current bank, lowest index on a tie.
    always_comb
    begin
        rbest_v = rd_work_reg[RIW'(int'(bank_reg) * READ_PORTS)];
        rbest_i = '0;
        for (int p = 1; p < READ_PORTS; p++)
        begin
            if (rd_work_reg[RIW'(int'(bank_reg) * READ_PORTS + p)] < rbest_v)
            begin
                rbest_v = rd_work_reg[RIW'(int'(bank_reg) * READ_PORTS + p)];
                rbest_i = RPW'(p);
            end
        end
        wbest_v = wr_work_reg[WIW'(int'(bank_reg) * WRITE_PORTS)];
        wbest_i = '0;
        for (int p = 1; p < WRITE_PORTS; p++)
        begin
            if (wr_work_reg[WIW'(int'(bank_reg) * WRITE_PORTS + p)] < wbest_v)
            begin
                wbest_v = wr_work_reg[WIW'(int'(bank_reg) * WRITE_PORTS + p)];
                wbest_i = WPW'(p);
            end
        end
        ridx = RIW'(int'(bank_reg) * READ_PORTS + int'(rbest_i));
        widx = WIW'(int'(bank_reg) * WRITE_PORTS + int'(wbest_i));
    end

    // Beat issue, overflow check and stripe stepping.
    always_comb
    begin
        pv       = req_reg.is_write ? wbest_v : rbest_v;
        sel      = (pv > issue_reg) ? pv : issue_reg;
        sel_lat  = {1'b0, sel} + (CYC_W+1)'(lat);
        r_sum    = {1'b0, r_reg} + {1'b0, br_reg};
        carry    = (r_sum >= {1'b0, stripe});
        r_new    = carry ? DSR_W'(r_sum - {1'b0, stripe}) : r_sum[DSR_W-1:0];
        b_sum    = (BW+2)'(bank_reg) + (BW+2)'(bqm_reg) + (BW+2)'(carry);
        bank_new = (b_sum >= (BW+2)'(BANKS)) ? BW'(b_sum - (BW+2)'(BANKS)) : b_sum[BW-1:0];
        proc_sum = (OFS_W+2)'(proc_reg) + (OFS_W+2)'(beat);
    end

    // Status to the controller.
    always_comb
    begin
        sts.div_done  = d0_done & d1_done;
        sts.range_err = (req_reg.byte_length == '0) || (req_reg.byte_offset > cap_eff)
                     || (({1'b0, req_reg.byte_offset} + {1'b0, req_reg.byte_length})
                         > {1'b0, cap_eff});
        sts.first_ovf = first_c[CYC_W];
        sts.beat_ovf  = sel_lat[CYC_W];
        sts.last_beat = (proc_sum >= (OFS_W+2)'(req_reg.byte_length));
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 25'd65536;
            width_reg <= 7'd8;
            lat_reg   <= 8'd1;
            dbeat_reg <= 11'd8;
            dset_reg  <= 16'd0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_CAPACITY: cap_reg   <= cfg_data;
                CFG_WIDTH:    width_reg <= cfg_data[6:0];
                CFG_LATENCY:  lat_reg   <= cfg_data[7:0];
                CFG_DMA_BEAT: dbeat_reg <= cfg_data[10:0];
                CFG_DMA_SET:  dset_reg  <= cfg_data[15:0];
                default:      ;
            endcase
        end
    end

    // Committed bookings change only when a request finishes without error.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NR; i++)
                rd_free_reg[i] <= '0;
            for (int i = 0; i < NW; i++)
                wr_free_reg[i] <= '0;
            eng_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.emit && (cmd.err == ERR_OK))
            begin
                rd_free_reg <= rd_work_reg;
                wr_free_reg <= wr_work_reg;
                if (req_reg.cmd)
                    eng_reg <= comp_reg;
            end
        end
    end

    // Request capture, working bookings and beat progress.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg     <= req;
            rd_work_reg <= rd_free_reg;
            wr_work_reg <= wr_free_reg;
        end
        if (cmd.beat_init)
        begin
            r_reg     <= d0_r;
            br_reg    <= d1_r;
            bank_reg  <= d0_m;
            bqm_reg   <= d1_m;
            issue_reg <= first_c[CYC_W-1:0];
            comp_reg  <= first_c[CYC_W-1:0];
            conf_reg  <= '0;
            proc_reg  <= '0;
        end
        else if (cmd.beat_step && !sts.beat_ovf)
        begin
            if (req_reg.is_write)
                wr_work_reg[widx] <= sel + CYC_W'(1);
            else
                rd_work_reg[ridx] <= sel + CYC_W'(1);
            if (sel_lat[CYC_W-1:0] > comp_reg)
                comp_reg <= sel_lat[CYC_W-1:0];
            if (pv > issue_reg)
                conf_reg <= conf_reg + OFS_W'(1);
            issue_reg <= issue_reg + CYC_W'(1);
            proc_reg  <= proc_sum[OFS_W:0];
            r_reg     <= r_new;
            bank_reg  <= bank_new;
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if (cmd.err == ERR_OK)
            begin
                rsp_reg.start_cycle      <= start_c;
                rsp_reg.completion_cycle <= comp_reg;
                rsp_reg.service_cycles   <= comp_reg - start_c;
                rsp_reg.queue_cycles     <= start_c - req_reg.arrival_cycle;
                rsp_reg.conflict_count   <= conf_reg;
            end
            else
            begin
                rsp_reg.start_cycle      <= '0;
                rsp_reg.completion_cycle <= '0;
                rsp_reg.service_cycles   <= '0;
                rsp_reg.queue_cycles     <= '0;
                rsp_reg.conflict_count   <= '0;
            end
            rsp_reg.error_code <= cmd.err;
        end
    end

    assign rsp  = rsp_reg;
    assign done = done_reg;

endmodule
`default_nettype wire

// ----- design/banked_port_access_scheduler_core.sv -----
// Top level of the banked port access scheduler: controller plus datapath.
// An item of n beats passes, after it is accepted, through a range check, bank index
// division, one step per beat and a finish state, then strobes from the result register.
// Errors found at the range or start check strobe straight from the check state.
// Busy falls in the strobe cycle: one item at a time, and the result cannot be stalled.
// Reset clears all port bookings, the DMA engine time and loads default registers.
`default_nettype none
module banked_port_access_scheduler_core
    import bpas_pkg::*;
#(
    parameter int BANKS       = 8,
    parameter int READ_PORTS  = 2,
    parameter int WRITE_PORTS = 1
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        req,
    output logic             done,
    output rsp_t             rsp,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [24:0] cfg_data
);

    ctl_cmd_t ctl_cmd;
    ctl_sts_t ctl_sts;
    logic     ctl_busy;

    assign cfg_ready = 1'b1;
    assign busy      = ctl_busy;

    bpas_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (ctl_sts),
        .cmd   (ctl_cmd),
        .busy  (ctl_busy)
    );

    bpas_dp #(
        .BANKS       (BANKS),
        .READ_PORTS  (READ_PORTS),
        .WRITE_PORTS (WRITE_PORTS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (ctl_cmd),
        .sts       (ctl_sts),
        .cfg_wen   (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp       (rsp),
        .done      (done)
    );

endmodule
`default_nettype wire
